// ----- design/tmg_pkg.sv -----
// ----------------------------------------------------------------------------
// tmg_pkg: shared types and constants for the glyph row renderer
// Holds the font store geometry, the request codes, the job record passed
// from the front end to the pixel back end, and the fixed 16-color palette.
// ----------------------------------------------------------------------------
`default_nettype none

package tmg_pkg;

  // Number of scan lines in one glyph (legal range 8 to 16; the row index is four bits).
  localparam int GLYPH_HEIGHT = 16;
  localparam int FONT_DEPTH   = 256 * GLYPH_HEIGHT;
  localparam int FONT_AW      = $clog2(FONT_DEPTH);

  localparam int PIXELS_PER_ROW = 8;
  localparam int COL_W          = $clog2(PIXELS_PER_ROW);

  // Depth of the job queue between front end and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    REQ_LOAD   = 1'b0,
    REQ_RENDER = 1'b1
  } req_t;

  // One glyph row ready to be turned into pixels.
  typedef struct packed {
    logic [7:0] font_bits;
    logic [3:0] fg_idx;
    logic [2:0] bg_idx;
  } job_t;

  // Standard 16-entry EGA palette, 0xRRGGBB.
  function automatic logic [23:0] tmg_palette(input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000aa;
      4'd2:    rgb = 24'h00aa00;
      4'd3:    rgb = 24'h00aaaa;
      4'd4:    rgb = 24'haa0000;
      4'd5:    rgb = 24'haa00aa;
      4'd6:    rgb = 24'haa5500;
      4'd7:    rgb = 24'haaaaaa;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'h5555ff;
      4'd10:   rgb = 24'h55ff55;
      4'd11:   rgb = 24'h55ffff;
      4'd12:   rgb = 24'hff5555;
      4'd13:   rgb = 24'hff55ff;
      4'd14:   rgb = 24'hffff55;
      default: rgb = 24'hffffff;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

// ----- design/tmg_front.sv -----
// ----------------------------------------------------------------------------
// tmg_front: request intake and font store
// Accepts load and render transactions. Loads write the font store at once;
// renders read it and present a job record to the queue in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tmg_front
  import tmg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_char_code,
  input  wire logic [7:0] in_cell_attribute,
  input  wire logic [3:0] in_row_in_glyph,
  input  wire logic [7:0] in_font_data,
  output logic            job_vld,
  output job_t            job,
  input  wire logic       q_full
);

  logic [7:0]         font_mem [FONT_DEPTH];
  logic [7:0]         font_rd_r;
  logic               s1_vld_r, s1_vld_nxt;
  logic [3:0]         s1_fg_r;
  logic [2:0]         s1_bg_r;
  logic               s1_row_ok_r;

  logic               in_acc;
  logic               is_render;
  logic               row_ok;
  logic               s1_load;
  logic               s1_take;
  logic [FONT_AW-1:0] font_addr;

  assign in_stall  = s1_vld_r && q_full;
  assign in_acc    = in_valid && !in_stall;
  assign is_render = (req_t'(in_req_type) == REQ_RENDER);
  assign row_ok    = (32'(in_row_in_glyph) < GLYPH_HEIGHT);
  assign font_addr = FONT_AW'(32'(in_char_code) * GLYPH_HEIGHT + 32'(in_row_in_glyph));
  assign s1_load   = in_acc && is_render;
  assign s1_take   = s1_vld_r && !q_full;

  always_comb begin
    if (s1_load) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_take) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  // Font store: one write or one read per cycle, registered read data.
  always_ff @(posedge clk) begin
    if (in_acc && !is_render && row_ok) begin
      font_mem[font_addr] <= in_font_data;
    end
    if (s1_load) begin
      font_rd_r <= font_mem[font_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_fg_r     <= in_cell_attribute[3:0];
      s1_bg_r     <= in_cell_attribute[6:4];
      s1_row_ok_r <= row_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  // A row beyond the glyph height renders as all background.
  assign job_vld        = s1_vld_r;
  assign job.font_bits  = s1_row_ok_r ? font_rd_r : 8'h00;
  assign job.fg_idx     = s1_fg_r;
  assign job.bg_idx     = s1_bg_r;

  // An accepted render always occupies the read stage in the next cycle.
  a_render_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && is_render) |=> s1_vld_r)
    else $error("accepted render did not reach the read stage");

endmodule

`default_nettype wire

// ----- design/tmg_queue.sv -----
// ----------------------------------------------------------------------------
// tmg_queue: job queue between front end and back end
// A small FIFO of job records so intake and pixel output stall separately.
// ----------------------------------------------------------------------------
`default_nettype none

module tmg_queue
  import tmg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      q_vld,
  output job_t      q_job
);

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_vld   = (count_r != '0);
  assign q_job   = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // The front end must hold its job, unchanged, while the queue is full.
  a_hold_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |=> (push && $stable(push_job)))
    else $error("job dropped or changed while the queue was full");

endmodule

`default_nettype wire

// ----- design/tmg_back.sv -----
// ----------------------------------------------------------------------------
// tmg_back: pixel serializer
// Takes one job at a time and emits its eight pixels, leftmost first, through
// a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tmg_back
  import tmg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_vld,
  input  job_t             q_job,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_pixel_rgb,
  output logic [2:0]       out_pixel_column,
  output logic             out_last_pixel
);

  job_t             act_r, act_nxt;
  logic             act_vld_r, act_vld_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [23:0]      out_rgb_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_last_r;

  logic             adv;
  logic             emit;
  logic             fin;
  logic             lit;
  logic [3:0]       color_idx;

  assign adv       = !out_vld_r || !out_stall;
  assign emit      = adv && act_vld_r;
  assign fin       = emit && (32'(col_r) == PIXELS_PER_ROW - 1);
  assign q_pop     = q_vld && (!act_vld_r || fin);
  assign lit       = act_r.font_bits[COL_W'(PIXELS_PER_ROW - 1) - col_r];
  assign color_idx = lit ? act_r.fg_idx : {1'b0, act_r.bg_idx};

  always_comb begin
    act_nxt     = act_r;
    act_vld_nxt = act_vld_r;
    col_nxt     = col_r;
    if (emit) begin
      col_nxt = col_r + 1'b1;
    end
    if (q_pop) begin
      act_nxt     = q_job;
      act_vld_nxt = 1'b1;
      col_nxt     = '0;
    end else if (fin) begin
      act_vld_nxt = 1'b0;
    end
    out_vld_nxt = adv ? act_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    if (emit) begin
      out_rgb_r  <= tmg_palette(color_idx);
      out_col_r  <= col_r;
      out_last_r <= (32'(col_r) == PIXELS_PER_ROW - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_vld_r <= 1'b0;
      col_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      act_vld_r <= act_vld_nxt;
      col_r     <= col_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pixel_rgb    = out_rgb_r;
  assign out_pixel_column = 3'(out_col_r);
  assign out_last_pixel   = out_last_r;

  // Once a pixel that is not the last one is taken, its neighbor follows.
  a_row_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_stall && !out_last_r)
      |=> (out_vld_r && out_col_r == $past(out_col_r) + 1'b1))
    else $error("glyph row interrupted before its last pixel");

  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_last_r == (32'(out_col_r) == PIXELS_PER_ROW - 1)))
    else $error("last pixel flag disagrees with the column");

endmodule

`default_nettype wire

// ----- design/text_mode_glyph_row_renderer_unit.sv -----
// ----------------------------------------------------------------------------
// text_mode_glyph_row_renderer_unit: text-mode glyph row renderer
// Stores a 256-glyph font and turns one glyph row of a character cell into
// eight 24-bit RGB pixels using the fixed 16-color EGA palette.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall  req_type, char_code,
//                                             cell_attribute, row_in_glyph,
//                                             font_data
//   out_      output     out_valid/out_stall  pixel_rgb, pixel_column,
//                                             last_pixel
//
// A load transaction produces no output. A render transaction produces
// eight output transactions, one per cycle while out_stall is low; the back
// end takes the next job as it emits the last pixel of the current one.
// Renders pass the font read, queue and active job registers to the output.
// Reset (rst_n low at a clock edge) empties the pipeline and the job queue;
// the font store keeps its contents and is undefined until written.
// out_stall holds the current pixel; the job queue lets intake continue until
// it fills and a job waits at the read stage, after which in_stall rises.
//
`default_nettype none

module text_mode_glyph_row_renderer_unit
  import tmg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [7:0]  in_cell_attribute,
  input  wire logic [3:0]  in_row_in_glyph,
  input  wire logic [7:0]  in_font_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_pixel_rgb,
  output logic [2:0]       out_pixel_column,
  output logic             out_last_pixel
);

  // Front end to queue.
  logic job_vld;
  job_t job;
  logic q_full;

  // Queue to back end.
  logic q_vld;
  job_t q_job;
  logic q_pop;

  // The front end handles loads itself and turns renders into job records
  // carrying the font byte and both palette indexes.
  tmg_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_char_code      (in_char_code),
    .in_cell_attribute (in_cell_attribute),
    .in_row_in_glyph   (in_row_in_glyph),
    .in_font_data      (in_font_data),
    .job_vld           (job_vld),
    .job               (job),
    .q_full            (q_full)
  );

  // The queue decouples intake from the pixel output so either side can
  // stall without blocking the other right away.
  tmg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_vld),
    .push_job (job),
    .full     (q_full),
    .pop      (q_pop),
    .q_vld    (q_vld),
    .q_job    (q_job)
  );

  // The back end serializes each job into eight pixels and picks up the next
  // job in the same cycle that the last pixel of the current one is emitted.
  tmg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_vld            (q_vld),
    .q_job            (q_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_rgb    (out_pixel_rgb),
    .out_pixel_column (out_pixel_column),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

`default_nettype wire
